// ----- rtl/core/ring_ranging_tof_to_distance_top_defines.svh -----
// assertion macros shared by the ring ranging checker
// no dependencies; included by the checker file only
`ifndef RING_RANGING_TOF_TO_DISTANCE_TOP_DEFINES_SVH
`define RING_RANGING_TOF_TO_DISTANCE_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define RRTD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define RRTD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rrtd_pkg.sv -----
// shared types and constants for the ring ranging distance block
// no dependencies
`default_nettype none

package rrtd_pkg;

    // widths fixed by the register and result formats
    localparam int STAMP_BITS_DEF = 40;
    localparam int DELAY_W        = 40;
    localparam int TOF_W          = 20;
    localparam int DIST_W         = 33;
    localparam int ROLE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 40;

    // half-tick lower limits, as magnitudes
    localparam int LOW_LIMIT      = 1000;
    localparam int LOW_LIMIT_WIDE = 2000;

    // round(c / (499.2e6 * 128) * 2^23): half ticks to 2^-24 metres
    localparam int SCALE_W    = 16;
    localparam int DIST_SCALE = 39357;

    // register reset values
    localparam logic [TOF_W-1:0] TOF_MAX_RESET = TOF_W'(127885);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOF_MAX = 2'd2;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_FIRST  = 2'd0,
        ROLE_SECOND = 2'd1,
        ROLE_THIRD  = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_INVALID = 2'd2
    } t_status;

    // one checked time of flight, zero unless positive and in range
    typedef struct packed {
        logic             good;
        logic [TOF_W-1:0] tof;
    } t_tof_res;

    typedef struct packed {
        t_tof_res p1p2;
        t_tof_res p1p3;
        t_tof_res p2p3;
        t_status  status;
    } t_round_res;

endpackage

`default_nettype wire

// ----- rtl/core/rrtd_tof_calc.sv -----
// half-tick time of flight sums and range checks for one round
// depends on rrtd_pkg
`default_nettype none

module rrtd_tof_calc
    import rrtd_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic [STAMP_BITS-1:0] i_stamp1,
    input  wire logic [STAMP_BITS-1:0] i_stamp2,
    input  wire logic [STAMP_BITS-1:0] i_stamp3,
    input  wire logic [STAMP_BITS-1:0] i_stamp4,
    input  wire logic [STAMP_BITS-1:0] i_stamp5,
    input  wire logic [STAMP_BITS-1:0] i_stamp6,
    input  wire logic                  i_round_ok,
    input  wire logic [ROLE_W-1:0]     i_role,
    input  wire logic [DELAY_W-1:0]    i_delay,
    input  wire logic [TOF_W-1:0]      i_tof_max,
    output t_round_res                 o_res
);

    // enough headroom for six terms of the wider operand
    localparam int OP_W = (STAMP_BITS > DELAY_W) ? STAMP_BITS : DELAY_W;
    localparam int HW   = OP_W + 4;

    logic signed [HW-1:0] t1, t2, t3, t4, t5, t6, dd;
    logic signed [HW-1:0] h12, h13, h23;
    logic signed [HW-1:0] low12, low_std, tmax;
    t_tof_res             c12, c13, c23;

    // zero-extend operands into the signed sum width
    assign t1 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp1});
    assign t2 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp2});
    assign t3 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp3});
    assign t4 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp4});
    assign t5 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp5});
    assign t6 = $signed({{(HW-STAMP_BITS){1'b0}}, i_stamp6});
    assign dd = $signed({{(HW-DELAY_W){1'b0}}, i_delay});

    assign low_std = -$signed(HW'(LOW_LIMIT));
    assign tmax    = $signed({{(HW-TOF_W){1'b0}}, i_tof_max});

    // formula set per node role, code three falls back to the first set
    always_comb begin
        low12 = low_std;
        case (i_role)
            ROLE_SECOND: begin
                h23 = t3 - t2 - dd;
                h13 = t5 - t3 - (dd <<< 1);
                h12 = (t4 <<< 1) - t2 - t5 - dd;
            end
            ROLE_THIRD: begin
                h13   = t4 - t3 - dd;
                h23   = t6 - t5 - dd;
                h12   = (t2 <<< 1) - (t1 <<< 1) + t4 - t6;
                low12 = -$signed(HW'(LOW_LIMIT_WIDE));
            end
            default: begin
                h12 = t2 - t1 - dd;
                h13 = t5 - t4 - dd;
                h23 = (t6 <<< 1) - t4 - t5 - t2 + t1 - (dd <<< 1);
            end
        endcase
    end

    // range check; negative values in range clamp to zero
    function automatic t_tof_res judge(
        input logic signed [HW-1:0] h,
        input logic signed [HW-1:0] low,
        input logic signed [HW-1:0] hi
    );
        t_tof_res r;
        r.good = (h >= low) && (h <= hi);
        r.tof  = (r.good && !h[HW-1]) ? h[TOF_W-1:0] : '0;
        return r;
    endfunction

    assign c12 = judge(h12, low12, tmax);
    assign c13 = judge(h13, low_std, tmax);
    assign c23 = judge(h23, low_std, tmax);

    // an invalid round overrides every check
    always_comb begin
        if (!i_round_ok) begin
            o_res.p1p2   = '0;
            o_res.p1p3   = '0;
            o_res.p2p3   = '0;
            o_res.status = STATUS_INVALID;
        end else begin
            o_res.p1p2   = c12;
            o_res.p1p3   = c13;
            o_res.p2p3   = c23;
            o_res.status = (c12.good && c13.good && c23.good) ? STATUS_OK : STATUS_RANGE;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rrtd_scale.sv -----
// half-tick time of flight to 2^-24 metre distance with saturation
// depends on rrtd_pkg
`default_nettype none

module rrtd_scale
    import rrtd_pkg::*;
(
    input  wire t_tof_res          i_tof,
    output logic [DIST_W-1:0]      o_dist
);

    localparam int PROD_W = TOF_W + SCALE_W;

    logic [PROD_W-1:0] w_prod;

    // constant multiply, then clip to the distance width
    assign w_prod = PROD_W'(i_tof.tof) * PROD_W'(DIST_SCALE);
    assign o_dist = (|w_prod[PROD_W-1:DIST_W]) ? {DIST_W{1'b1}} : w_prod[DIST_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/ring_ranging_tof_to_distance_top.sv -----
// ring ranging top level: config registers, input, check and result stages
// depends on rrtd_pkg, rrtd_tof_calc, rrtd_scale
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries six timestamps and a round
//   valid flag. Output channel o_out_valid/i_out_ready carries three
//   distances, their good bits and a round status.
//   Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0
//   role, 1 reply delay, 2 upper time of flight limit; index 3 is ignored.
//   Write it only while no transaction is in flight.
//   Path: an accepted transaction moves through the three register stages
//   (input, checked time of flight, scaled result) to the output.
//   Throughput: one transaction per cycle through these stages unless stalled.
//   Stall: each stage holds while the next is full and stalled; with the
//   output stalled the pipe still absorbs up to two more transactions.
//   Reset: all stages empty, role 0, reply delay 0, limit 127885 half ticks.
`default_nettype none

module ring_ranging_tof_to_distance_top
    import rrtd_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg1,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg2,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg3,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg4,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg5,
    input  wire logic [STAMP_BITS-1:0] i_stamp_msg6,
    input  wire logic                  i_round_ok,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [DIST_W-1:0]          o_dist_p1p2,
    output logic [DIST_W-1:0]          o_dist_p1p3,
    output logic [DIST_W-1:0]          o_dist_p2p3,
    output logic                       o_p1p2_good,
    output logic                       o_p1p3_good,
    output logic                       o_p2p3_good,
    output logic [1:0]                 o_round_status
);

    logic [ROLE_W-1:0]     r_role;
    logic [DELAY_W-1:0]    r_delay;
    logic [TOF_W-1:0]      r_tof_max;

    logic                  r_a_valid;
    logic [STAMP_BITS-1:0] r_a_stamp1, r_a_stamp2, r_a_stamp3;
    logic [STAMP_BITS-1:0] r_a_stamp4, r_a_stamp5, r_a_stamp6;
    logic                  r_a_round_ok;

    logic                  r_b_valid;
    t_round_res            r_b_res;
    t_round_res            n_b_res;

    logic                  r_out_valid;
    logic [DIST_W-1:0]     r_out_d12, r_out_d13, r_out_d23;
    logic [DIST_W-1:0]     n_out_d12, n_out_d13, n_out_d23;
    logic                  r_out_g12, r_out_g13, r_out_g23;
    t_status               r_out_status;

    logic                  w_out_adv, w_b_adv, w_a_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role    <= ROLE_FIRST;
            r_delay   <= '0;
            r_tof_max <= TOF_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROLE:    r_role    <= i_cfg_data[ROLE_W-1:0];
                CFG_DELAY:   r_delay   <= i_cfg_data[DELAY_W-1:0];
                CFG_TOF_MAX: r_tof_max <= i_cfg_data[TOF_W-1:0];
                default:     ;
            endcase
        end
    end

    // stage advance: a stage loads when empty or when the next one moves
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_b_adv    = !r_b_valid || w_out_adv;
    assign w_a_adv    = !r_a_valid || w_b_adv;
    assign o_in_ready = w_a_adv;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_adv) begin
                r_a_valid <= i_in_valid;
            end
            if (w_b_adv) begin
                r_b_valid <= r_a_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_a_stamp1   <= i_stamp_msg1;
            r_a_stamp2   <= i_stamp_msg2;
            r_a_stamp3   <= i_stamp_msg3;
            r_a_stamp4   <= i_stamp_msg4;
            r_a_stamp5   <= i_stamp_msg5;
            r_a_stamp6   <= i_stamp_msg6;
            r_a_round_ok <= i_round_ok;
        end
    end

    // time of flight sums and range checks
    rrtd_tof_calc #(
        .STAMP_BITS (STAMP_BITS)
    ) u_tof_calc (
        .i_stamp1   (r_a_stamp1),
        .i_stamp2   (r_a_stamp2),
        .i_stamp3   (r_a_stamp3),
        .i_stamp4   (r_a_stamp4),
        .i_stamp5   (r_a_stamp5),
        .i_stamp6   (r_a_stamp6),
        .i_round_ok (r_a_round_ok),
        .i_role     (r_role),
        .i_delay    (r_delay),
        .i_tof_max  (r_tof_max),
        .o_res      (n_b_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_b_res <= n_b_res;
        end
    end

    // scaling to distance units
    rrtd_scale u_scale_p1p2 (
        .i_tof  (r_b_res.p1p2),
        .o_dist (n_out_d12)
    );

    rrtd_scale u_scale_p1p3 (
        .i_tof  (r_b_res.p1p3),
        .o_dist (n_out_d13)
    );

    rrtd_scale u_scale_p2p3 (
        .i_tof  (r_b_res.p2p3),
        .o_dist (n_out_d23)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out_d12    <= n_out_d12;
            r_out_d13    <= n_out_d13;
            r_out_d23    <= n_out_d23;
            r_out_g12    <= r_b_res.p1p2.good;
            r_out_g13    <= r_b_res.p1p3.good;
            r_out_g23    <= r_b_res.p2p3.good;
            r_out_status <= r_b_res.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dist_p1p2    = r_out_d12;
    assign o_dist_p1p3    = r_out_d13;
    assign o_dist_p2p3    = r_out_d23;
    assign o_p1p2_good    = r_out_g12;
    assign o_p1p3_good    = r_out_g13;
    assign o_p2p3_good    = r_out_g23;
    assign o_round_status = r_out_status;

endmodule

`default_nettype wire

// ----- rtl/core/rrtd_checker.sv -----
// port-level assertions for the ring ranging top level, bound to it
// depends on rrtd_pkg and ring_ranging_tof_to_distance_top_defines.svh
`default_nettype none

`include "ring_ranging_tof_to_distance_top_defines.svh"

module rrtd_checker
    import rrtd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [DIST_W-1:0] o_dist_p1p2,
    input  wire logic [DIST_W-1:0] o_dist_p1p3,
    input  wire logic [DIST_W-1:0] o_dist_p2p3,
    input  wire logic              o_p1p2_good,
    input  wire logic              o_p1p3_good,
    input  wire logic              o_p2p3_good,
    input  wire logic [1:0]        o_round_status
);

    // stalled result transaction holds its distances
    `RRTD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_dist_p1p2) && $stable(o_dist_p1p3) && $stable(o_dist_p2p3), "stalled result changed")

    // invalid round reports nothing good and no distance
    `RRTD_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_out_valid && o_round_status == STATUS_INVALID, !o_p1p2_good && !o_p1p3_good && !o_p2p3_good && o_dist_p1p2 == '0 && o_dist_p1p3 == '0 && o_dist_p2p3 == '0, "invalid round with data")

    // all-good status needs all three checks passed
    `RRTD_ASSERT_NOW(a_ok_all_good, i_clk, i_rst_n, o_out_valid && o_round_status == STATUS_OK, o_p1p2_good && o_p1p3_good && o_p2p3_good, "ok status with failed check")

    // a failed check leaves no distance behind
    `RRTD_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && (!o_p1p2_good || !o_p1p3_good || !o_p2p3_good), (o_p1p2_good || o_dist_p1p2 == '0) && (o_p1p3_good || o_dist_p1p3 == '0) && (o_p2p3_good || o_dist_p2p3 == '0), "distance on failed check")

endmodule

bind ring_ranging_tof_to_distance_top rrtd_checker u_rrtd_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the ring ranging distance block
// predicts each result from the six stamps and the register copies
// depends on rrtd_pkg and ring_ranging_tof_to_distance_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rrtd_pkg::*;

    localparam int SW              = STAMP_BITS_DEF;
    localparam int GAP_MAX         = 12;
    localparam int QUIET_LIMIT     = 1000;
    localparam int HOLD_CYCLES     = 100;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int PRESSURE_ITEMS  = 60;
    localparam int MAX_PRINTS      = 40;

    // role code outside the enum, and the index with no register
    localparam logic [ROLE_W-1:0]    ROLE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint DIST_SAT    = (longint'(1) <<< DIST_W) - 1;
    localparam longint TOF_MAX_ALL = (longint'(1) <<< TOF_W) - 1;
    localparam longint DELAY_ALL   = (longint'(1) <<< DELAY_W) - 1;

    typedef logic [5:0][SW-1:0] stamp_set_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_p1p2;
        logic [DIST_W-1:0] dist_p1p3;
        logic [DIST_W-1:0] dist_p2p3;
        logic              p1p2_good;
        logic              p1p3_good;
        logic              p2p3_good;
        t_status           status;
    } ranges_t;

    // dut signals
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SW-1:0]         i_stamp_msg1;
    logic [SW-1:0]         i_stamp_msg2;
    logic [SW-1:0]         i_stamp_msg3;
    logic [SW-1:0]         i_stamp_msg4;
    logic [SW-1:0]         i_stamp_msg5;
    logic [SW-1:0]         i_stamp_msg6;
    logic                  i_round_ok;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DIST_W-1:0]     o_dist_p1p2;
    logic [DIST_W-1:0]     o_dist_p1p3;
    logic [DIST_W-1:0]     o_dist_p2p3;
    logic                  o_p1p2_good;
    logic                  o_p1p3_good;
    logic                  o_p2p3_good;
    logic [1:0]            o_round_status;

    // register copies kept by the predictor
    logic [ROLE_W-1:0]  role_cfg;
    logic [DELAY_W-1:0] delay_cfg;
    logic [TOF_W-1:0]   tof_max_cfg;

    ranges_t expected_ranges[$];
    bit      no_idle        = 1'b0;
    int      hold_request   = 0;
    int      mismatch_count = 0;

    ring_ranging_tof_to_distance_top i_dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_in_valid,
        .o_in_ready,
        .i_stamp_msg1,
        .i_stamp_msg2,
        .i_stamp_msg3,
        .i_stamp_msg4,
        .i_stamp_msg5,
        .i_stamp_msg6,
        .i_round_ok,
        .o_out_valid,
        .i_out_ready,
        .o_dist_p1p2,
        .o_dist_p1p3,
        .o_dist_p2p3,
        .o_p1p2_good,
        .o_p1p3_good,
        .o_p2p3_good,
        .o_round_status
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // uniform stamp over the full 40-bit range
    function automatic longint rand_stamp();
        return longint'({$urandom_range(255, 0), $urandom});
    endfunction

    // range check and scaling of one half-tick flight time
    function automatic void judge_tof(input longint h, input longint low_mag,
                                      output logic [DIST_W-1:0] dist_val, output logic good);
        longint limit;
        longint prod;
        limit = longint'(tof_max_cfg);
        dist_val = '0;
        if (h < 0) begin
            good = (h >= -low_mag);
        end else if (h > limit) begin
            good = 1'b0;
        end else begin
            prod = h * DIST_SCALE;
            good = 1'b1;
            dist_val = (prod > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(prod);
        end
    endfunction

    // distances, good bits and status of one round under the current registers
    function automatic ranges_t predict_ranges(input stamp_set_t st, input logic ok);
        ranges_t r;
        longint  t[6];
        longint  d;
        longint  h12;
        longint  h13;
        longint  h23;
        longint  low12;
        int      i;
        r = '0;
        if (!ok) begin
            r.status = STATUS_INVALID;
            return r;
        end
        for (i = 0; i < 6; i++) begin
            t[i] = longint'(st[i]);
        end
        d = longint'(delay_cfg);
        low12 = LOW_LIMIT;
        case (role_cfg)
            ROLE_SECOND: begin
                h23 = t[2] - t[1] - d;
                h13 = t[4] - t[2] - 2 * d;
                h12 = 2 * t[3] - t[1] - t[4] - d;
            end
            ROLE_THIRD: begin
                h13 = t[3] - t[2] - d;
                h23 = t[5] - t[4] - d;
                h12 = 2 * t[1] - 2 * t[0] + t[3] - t[5];
                low12 = LOW_LIMIT_WIDE;
            end
            // first node set, also taken by the spare role code
            default: begin
                h12 = t[1] - t[0] - d;
                h13 = t[4] - t[3] - d;
                h23 = 2 * t[5] - t[3] - t[4] - t[1] + t[0] - 2 * d;
            end
        endcase
        judge_tof(h12, low12, r.dist_p1p2, r.p1p2_good);
        judge_tof(h13, LOW_LIMIT, r.dist_p1p3, r.p1p3_good);
        judge_tof(h23, LOW_LIMIT, r.dist_p2p3, r.p2p3_good);
        r.status = (r.p1p2_good && r.p1p3_good && r.p2p3_good) ? STATUS_OK : STATUS_RANGE;
        return r;
    endfunction

    // stamps of a consistent round aiming at the given half-tick flight times
    function automatic stamp_set_t build_round(input longint h12, input longint h13,
                                               input longint h23);
        stamp_set_t st;
        longint     t[6];
        longint     d;
        longint     base;
        longint     span;
        longint     num;
        int         i;
        d = longint'(delay_cfg);
        span = (longint'(1) <<< SW) - 4 * d - (longint'(1) <<< 26);
        base = longint'(1) <<< 25;
        if (span > 0) begin
            base = base + (rand_stamp() % span);
        end
        // stamps that the role does not use stay fully random
        for (i = 0; i < 6; i++) begin
            t[i] = rand_stamp();
        end
        case (role_cfg)
            ROLE_SECOND: begin
                t[1] = base;
                t[2] = t[1] + d + h23;
                t[4] = t[2] + 2 * d + h13;
                t[3] = (h12 + t[1] + t[4] + d) >>> 1;
            end
            ROLE_THIRD: begin
                t[0] = base;
                t[2] = base + longint'($urandom_range(1 << 20, 0));
                t[3] = t[2] + d + h13;
                t[4] = base + longint'($urandom_range(1 << 20, 0));
                t[5] = t[4] + d + h23;
                num = h12 - t[3] + t[5];
                // shift the fifth and sixth stamps together to hit h12 exactly
                if ((num & 1) != 0) begin
                    t[4] = t[4] + 1;
                    t[5] = t[5] + 1;
                    num = num + 1;
                end
                t[1] = t[0] + (num >>> 1);
            end
            default: begin
                t[0] = base;
                t[1] = t[0] + d + h12;
                t[3] = base + longint'($urandom_range(1 << 20, 0));
                t[4] = t[3] + d + h13;
                t[5] = (h23 + t[3] + t[4] + t[1] - t[0] + 2 * d) >>> 1;
            end
        endcase
        for (i = 0; i < 6; i++) begin
            st[i] = SW'(t[i]);
        end
        return st;
    endfunction

    // flight time target: limits, their neighbors, zero, or random
    function automatic longint pick_target(input longint low_mag);
        longint limit;
        limit = longint'(tof_max_cfg);
        case ($urandom_range(9, 0))
            0: return -low_mag;
            1: return -low_mag - 1;
            2: return 0;
            3: return limit;
            4: return limit + 1;
            5: return -longint'($urandom_range(low_mag, 1));
            9: return longint'($urandom_range(limit + 10000, 0)) - 5000;
            default: return longint'($urandom_range(limit, 0));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // one input transaction, predicted when it is accepted
    task automatic send_round(input stamp_set_t st, input logic ok);
        int gap;
        gap = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_stamp_msg1 <= st[0];
        i_stamp_msg2 <= st[1];
        i_stamp_msg3 <= st[2];
        i_stamp_msg4 <= st[3];
        i_stamp_msg5 <= st[4];
        i_stamp_msg6 <= st[5];
        i_round_ok   <= ok;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_ranges.push_back(predict_ranges(st, ok));
    endtask

    // mostly well-formed rounds, some flagged invalid, some pure noise
    task automatic send_random_round();
        stamp_set_t st;
        int         kind;
        int         i;
        longint     low12;
        kind = $urandom_range(19, 0);
        low12 = (role_cfg == ROLE_THIRD) ? LOW_LIMIT_WIDE : LOW_LIMIT;
        if (kind < 3) begin
            for (i = 0; i < 6; i++) begin
                st[i] = SW'(rand_stamp());
            end
            send_round(st, 1'($urandom_range(1, 0)));
        end else begin
            st = build_round(pick_target(low12), pick_target(LOW_LIMIT),
                             pick_target(LOW_LIMIT));
            send_round(st, kind != 3);
        end
    endtask

    // stop offering and let the pipe drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROLE:    role_cfg    = data[ROLE_W-1:0];
            CFG_DELAY:   delay_cfg   = data[DELAY_W-1:0];
            CFG_TOF_MAX: tof_max_cfg = data[TOF_W-1:0];
            default: ;
        endcase
    endtask

    // all three registers, junk in the unused upper data bits
    task automatic configure(input logic [ROLE_W-1:0] role, input longint delay,
                             input longint tmax);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'(rand_stamp());
        wait_idle();
        write_reg(CFG_ROLE, {junk[CFG_DATA_W-1:ROLE_W], role});
        write_reg(CFG_DELAY, CFG_DATA_W'(delay));
        write_reg(CFG_TOF_MAX, {junk[CFG_DATA_W-1:TOF_W], TOF_W'(tmax)});
    endtask

    // reset register values: invalid rounds, flat rounds, limits
    task automatic test_reset_defaults();
        send_round('0, 1'b0);
        send_round('1, 1'b0);
        send_round('0, 1'b1);
        send_round('1, 1'b1);
        send_round(build_round(-LOW_LIMIT, longint'(TOF_MAX_RESET), 0), 1'b1);
        send_round(build_round(-LOW_LIMIT - 1, longint'(TOF_MAX_RESET) + 1, 0), 1'b1);
    endtask

    // range limits for every role code, wide lower limit on the third
    task automatic test_role_limits();
        logic [ROLE_W-1:0] codes [4];
        longint            tmax;
        longint            low12;
        int                k;
        codes = '{ROLE_FIRST, ROLE_SECOND, ROLE_THIRD, ROLE_SPARE};
        for (k = 0; k < 4; k++) begin
            tmax = longint'($urandom_range(TOF_MAX_ALL - 1000, 1000));
            configure(codes[k], longint'($urandom), tmax);
            low12 = (codes[k] == ROLE_THIRD) ? LOW_LIMIT_WIDE : LOW_LIMIT;
            send_round(build_round(-low12, -LOW_LIMIT, tmax), 1'b1);
            send_round(build_round(-low12 - 1, tmax + 1, -LOW_LIMIT - 1), 1'b1);
            // small negative flight times clamp to zero
            send_round(build_round(0, -1, 1), 1'b1);
        end
    endtask

    // product saturation at the widest limit, largest reply delay
    task automatic test_distance_saturation();
        configure(ROLE_THIRD, 0, TOF_MAX_ALL);
        send_round(build_round(-LOW_LIMIT_WIDE, 218256, 218257), 1'b1);
        send_round(build_round(TOF_MAX_ALL, TOF_MAX_ALL, 0), 1'b1);
        configure(ROLE_FIRST, DELAY_ALL, 0);
        send_round(build_round(0, -LOW_LIMIT, 0), 1'b1);
    endtask

    // a write to the spare index leaves the registers alone
    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_UNUSED, CFG_DATA_W'(rand_stamp()));
        send_round(build_round(1, 2, 3), 1'b1);
        send_round(build_round(-LOW_LIMIT, 0, longint'(tof_max_cfg)), 1'b1);
    endtask

    // random rounds over several register settings, some phases with no idling
    task automatic test_random_rounds();
        int phase;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: configure(ROLE_FIRST, longint'($urandom_range(1 << 20, 0)),
                             longint'(TOF_MAX_RESET));
                1: configure(ROLE_SECOND, 0, TOF_MAX_ALL);
                2: configure(ROLE_THIRD, longint'($urandom_range(1 << 30, 0)), 0);
                3: configure(ROLE_SPARE, rand_stamp(),
                             longint'($urandom_range(TOF_MAX_ALL, 0)));
                4: configure(ROLE_SECOND, rand_stamp() >>> 4,
                             longint'($urandom_range(TOF_MAX_ALL, 0)));
                5: configure(ROLE_THIRD, longint'($urandom_range(1 << 24, 0)),
                             longint'(TOF_MAX_RESET));
                default: configure(ROLE_FIRST, DELAY_ALL, TOF_MAX_ALL);
            endcase
            no_idle = (phase % 3 == 2);
            repeat (ITEMS_PER_PHASE) send_random_round();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_back_pressure();
        configure(ROLE_SECOND, longint'($urandom), longint'(TOF_MAX_RESET));
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (PRESSURE_ITEMS) send_random_round();
        no_idle = 1'b0;
    endtask

    // output ready with random stalls and an occasional long hold
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        ranges_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch("result transaction with none expected");
            end else begin
                want = expected_ranges.pop_front();
                check_field("dist_p1p2", o_dist_p1p2, want.dist_p1p2);
                check_field("dist_p1p3", o_dist_p1p3, want.dist_p1p3);
                check_field("dist_p2p3", o_dist_p2p3, want.dist_p2p3);
                check_field("p1p2_good", o_p1p2_good, want.p1p2_good);
                check_field("p1p3_good", o_p1p3_good, want.p1p3_good);
                check_field("p2p3_good", o_p2p3_good, want.p2p3_good);
                check_field("round_status", o_round_status, want.status);
            end
        end
    end

    // end the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : test_sequence
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_ROLE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_stamp_msg1 = '0;
        i_stamp_msg2 = '0;
        i_stamp_msg3 = '0;
        i_stamp_msg4 = '0;
        i_stamp_msg5 = '0;
        i_stamp_msg6 = '0;
        i_round_ok   = 1'b0;
        role_cfg     = ROLE_FIRST;
        delay_cfg    = '0;
        tof_max_cfg  = TOF_MAX_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_role_limits();
        test_distance_saturation();
        test_spare_index();
        test_random_rounds();
        test_back_pressure();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- ring_ranging_tof_to_distance_top.f -----
+incdir+rtl/core
rtl/core/rrtd_pkg.sv
rtl/core/rrtd_tof_calc.sv
rtl/core/rrtd_scale.sv
rtl/core/ring_ranging_tof_to_distance_top.sv
rtl/core/rrtd_checker.sv
verif/tb_top.sv
